[rtl/stfm_pkg.sv]
// stfm_pkg: shared types and constants for the sorted trimmed-mean filter
// used by stfm_cell and sorted_trimmed_mean_filter_unit; no dependencies
package stfm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int STORE_DEPTH  = 6;
  localparam int CARRY_COUNT  = 2;
  localparam int FILL_W       = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_WIDTH + 1;

  localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(CARRY_COUNT);
  localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(STORE_DEPTH - 1);

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [SUM_W-1:0]        sum_t;

  typedef struct packed {
    logic en;
    logic occupied;
    logic at_end;
    logic load_carry;
  } cell_ctrl_t;

endpackage

[rtl/stfm_cell.sv]
// stfm_cell: one slot of the sorted store with compare-and-shift insertion
// depends on stfm_pkg
module stfm_cell
  import stfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  sample_t    sample,
  input  sample_t    left_value,
  input  logic       left_shift,
  input  sample_t    carry_value,
  output sample_t    value,
  output sample_t    value_next,
  output logic       shift
);

  logic take_sample;

  assign shift       = ctrl.occupied && (sample < value);
  assign take_sample = ctrl.occupied ? shift : ctrl.at_end;

  always_comb begin
    if (left_shift) begin
      value_next = left_value;
    end else if (take_sample) begin
      value_next = sample;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctrl.en) begin
      value <= ctrl.load_carry ? carry_value : value_next;
    end
  end

endmodule

[rtl/sorted_trimmed_mean_filter_unit.sv]
// sorted_trimmed_mean_filter_unit: six-cell sorted store, emits the mean of the
// middle two values every fourth sample; depends on stfm_pkg and stfm_cell
// a result is registered and valid in the cycle after the beat that fills the sixth slot
// throughput: one sample per cycle unless in_stall holds the input, as insertion is combinational across the cells
// input stalls only on a batch-ending beat while an earlier result is still unread
// reset: store cleared to zeros, fill count two, no result pending
module sorted_trimmed_mean_filter_unit
  import stfm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t sample,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t filtered_value
);

  fill_t      fill_count;
  fill_t      fill_count_next;
  logic       in_accept;
  logic       batch_done;
  sum_t       mid_sum;
  sample_t    values [STORE_DEPTH];
  sample_t    nexts  [STORE_DEPTH];
  logic       shifts [STORE_DEPTH];
  cell_ctrl_t ctrls  [STORE_DEPTH];
  logic       sorted_ok;

  assign in_stall   = (fill_count == FILL_LAST) && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign batch_done = in_accept && (fill_count == FILL_LAST);

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    sample_t left_value;
    logic    left_shift;
    sample_t carry_value;

    assign ctrls[k].en         = in_accept;
    assign ctrls[k].occupied   = fill_count > FILL_W'(k);
    assign ctrls[k].at_end     = fill_count == FILL_W'(k);
    assign ctrls[k].load_carry = batch_done && (k < CARRY_COUNT);

    if (k == 0) begin : g_first
      assign left_value = '0;
      assign left_shift = 1'b0;
    end else begin : g_rest
      assign left_value = values[k-1];
      assign left_shift = shifts[k-1];
    end

    if (k < CARRY_COUNT) begin : g_carry
      assign carry_value = nexts[k+CARRY_COUNT];
    end else begin : g_nocarry
      assign carry_value = nexts[k];
    end

    stfm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrls[k]),
      .sample      (sample),
      .left_value  (left_value),
      .left_shift  (left_shift),
      .carry_value (carry_value),
      .value       (values[k]),
      .value_next  (nexts[k]),
      .shift       (shifts[k])
    );
  end

  // middle two of the six sorted values
  assign mid_sum = {1'b0, nexts[CARRY_COUNT]} + {1'b0, nexts[CARRY_COUNT+1]};

  always_comb begin
    if (batch_done) begin
      fill_count_next = FILL_RESET;
    end else if (in_accept) begin
      fill_count_next = fill_count + FILL_W'(1);
    end else begin
      fill_count_next = fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= FILL_RESET;
      out_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      if (batch_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_done) begin
      filtered_value <= mid_sum[SUM_W-1:1];
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 0; k < STORE_DEPTH - 1; k++) begin
      if ((fill_count > FILL_W'(k + 1)) && (values[k] > values[k+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (fill_count >= FILL_RESET) && (fill_count <= FILL_LAST))
    else $error("fill count out of range");

  a_store_sorted: assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("occupied store entries not ascending");

  a_batch_wrap: assert property (@(posedge clk) disable iff (rst)
    batch_done |=> (fill_count == FILL_RESET) && out_valid)
    else $error("batch end did not restart fill and post a result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (fill_count != FILL_LAST) && out_valid && !out_stall)
      |=> !out_valid)
    else $error("result beat appeared without a batch end");

endmodule
